// ----- design/rhd_pkg.sv -----
package rhd_pkg;

  // image limits
  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int LINE_DEPTH   = MAX_WIDTH / 2;

  // field widths
  localparam int CH_W      = 8;
  localparam int SUM_W     = CH_W + 1;
  localparam int SIZE_W    = 13;
  localparam int CNT_W     = $clog2((MAX_WIDTH > HEIGHT_LIMIT) ? MAX_WIDTH : HEIGHT_LIMIT);
  localparam int DIM_W     = (SIZE_W > CNT_W + 1) ? SIZE_W : CNT_W + 1;
  localparam int IDX_W     = $clog2(LINE_DEPTH);
  localparam int CFG_IDX_W = 2;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [SUM_W-1:0] alpha;
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } pair_t;

  localparam int PAIR_W = $bits(pair_t);

  // position decode of the pixel being offered
  typedef struct packed {
    logic             in_image;
    logic             odd_col;
    logic             odd_row;
    logic [IDX_W-1:0] idx;
    logic             row_end;
    logic             frame_end;
  } pos_t;

  function automatic pair_t pair_add(pixel_t a, pixel_t b);
    pair_t s;
    s.red   = SUM_W'(a.red)   + SUM_W'(b.red);
    s.green = SUM_W'(a.green) + SUM_W'(b.green);
    s.blue  = SUM_W'(a.blue)  + SUM_W'(b.blue);
    s.alpha = SUM_W'(a.alpha) + SUM_W'(b.alpha);
    return s;
  endfunction

  // sum of two pair sums, divided by four with truncation
  function automatic logic [CH_W-1:0] quad_chan(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] t;
    t = (SUM_W + 1)'(a) + (SUM_W + 1)'(b);
    return t[SUM_W:2];
  endfunction

  function automatic pixel_t quad_avg(pair_t up, pair_t dn);
    pixel_t p;
    p.red   = quad_chan(up.red,   dn.red);
    p.green = quad_chan(up.green, dn.green);
    p.blue  = quad_chan(up.blue,  dn.blue);
    p.alpha = quad_chan(up.alpha, dn.alpha);
    return p;
  endfunction

endpackage

// ----- design/rhd_if.sv -----
interface rhd_pix_in_if;
  import rhd_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  logic [CH_W-1:0] alpha_in;
  logic            frame_start;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, frame_start,
                  input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, frame_start,
                  output ready);
endinterface

interface rhd_pix_out_if;
  import rhd_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic [CH_W-1:0] alpha_out;
  logic            row_end;
  logic            frame_end;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, row_end, frame_end,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, row_end, frame_end,
                  output ready);
endinterface

interface rhd_cfg_if;
  import rhd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/rhd_ram.sv -----
module rhd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/rhd_pos.sv -----
module rhd_pos (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        frame_start,
  input  logic [rhd_pkg::SIZE_W-1:0]  in_width,
  input  logic [rhd_pkg::SIZE_W-1:0]  in_height,
  output rhd_pkg::pos_t               pos
);
  import rhd_pkg::*;

  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;
  logic [CNT_W-1:0] col, row;
  logic [DIM_W-1:0] w, h, col_x, row_x, size_w_x, size_h_x;
  logic [DIM_W-2:0] half_w_m1, half_h_m1;
  logic             col_last, row_last;

  // saturate sizes to the supported range
  always_comb begin
    size_w_x = DIM_W'(in_width);
    size_h_x = DIM_W'(in_height);
    if (size_w_x < DIM_W'(2)) begin
      w = DIM_W'(2);
    end else if (size_w_x > DIM_W'(MAX_WIDTH)) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = size_w_x;
    end
    if (size_h_x < DIM_W'(2)) begin
      h = DIM_W'(2);
    end else if (size_h_x > DIM_W'(HEIGHT_LIMIT)) begin
      h = DIM_W'(HEIGHT_LIMIT);
    end else begin
      h = size_h_x;
    end
  end

  always_comb begin
    col       = frame_start ? '0 : column_count;
    row       = frame_start ? '0 : row_count;
    col_x     = DIM_W'(col);
    row_x     = DIM_W'(row);
    half_w_m1 = w[DIM_W-1:1] - (DIM_W - 1)'(1);
    half_h_m1 = h[DIM_W-1:1] - (DIM_W - 1)'(1);

    pos.in_image  = (col_x < w) && (row_x < h);
    pos.odd_col   = col[0];
    pos.odd_row   = row[0];
    pos.idx       = col[IDX_W:1];
    pos.row_end   = ((DIM_W - 1)'(pos.idx) == half_w_m1);
    pos.frame_end = pos.row_end && (row_x[DIM_W-1:1] == half_h_m1);

    col_last = (col_x + DIM_W'(1)) >= w;
    row_last = (row_x + DIM_W'(1)) >= h;
    if (col_last) begin
      column_count_next = '0;
      row_count_next    = row_last ? '0 : row + CNT_W'(1);
    end else begin
      column_count_next = col + CNT_W'(1);
      row_count_next    = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// ----- design/rgba_half_downsampler.sv -----
// channel   dir  handshake      payload
// pix_in    in   valid/ready    red_in green_in blue_in alpha_in frame_start
// pix_out   out  valid/ready    red_out green_out blue_out alpha_out row_end frame_end
// cfg       in   valid/ready    index data (0: in_width, 1: in_height)
//
// one input word per clock while pix_out.ready is high; an output word passes stage 1
// and the result register after the odd-row, odd-column pixel that ends its 2x2 block
// the line store is a single write / single read ram, at most one access per word
// rst is synchronous: counters, left pixel and sizes (64 x 64) are restored;
// the line store is not cleared
// a full result register with pix_out.ready low stalls pix_in only once a
// second result is waiting behind it
module rgba_half_downsampler (
  input  logic                 clk,
  input  logic                 rst,
  rhd_pix_in_if.sink           pix_in,
  rhd_pix_out_if.source        pix_out,
  rhd_cfg_if.sink              cfg
);
  import rhd_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0] in_width;
  logic [SIZE_W-1:0] in_height;

  // position of the offered word
  pos_t              pos;
  logic              in_accept;
  logic              line_we;
  logic              line_re;
  pixel_t            pix;
  pair_t             pair_now;
  logic [PAIR_W-1:0] line_rdata;

  // even-column pixel waiting for its right neighbour
  pixel_t            left_pixel;

  // stage between the input and the result register
  logic              s1_valid;
  pair_t             s1_sum;
  logic              s1_row_end;
  logic              s1_frame_end;
  logic              s1_free;

  // result register
  logic              out_valid;
  pixel_t            out_pixel;
  logic              out_row_end;
  logic              out_frame_end;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width  <= SIZE_RESET;
      in_height <= SIZE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IN_WIDTH:  in_width  <= cfg.data;
        REG_IN_HEIGHT: in_height <= cfg.data;
        default: ;
      endcase
    end
  end

  rhd_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .advance     (in_accept),
    .frame_start (pix_in.frame_start),
    .in_width    (in_width),
    .in_height   (in_height),
    .pos         (pos)
  );

  // the stage may take a new word when it is empty or its word moves on
  assign s1_free      = !s1_valid || !out_valid || pix_out.ready;
  assign pix_in.ready = s1_free;
  assign in_accept    = pix_in.valid && pix_in.ready;

  always_comb begin
    pix.red   = pix_in.red_in;
    pix.green = pix_in.green_in;
    pix.blue  = pix_in.blue_in;
    pix.alpha = pix_in.alpha_in;
  end

  assign pair_now = pair_add(left_pixel, pix);
  // even rows park the pair sum, odd rows fetch the one from above
  assign line_we  = in_accept && pos.in_image && pos.odd_col && !pos.odd_row;
  assign line_re  = in_accept && pos.in_image && pos.odd_col && pos.odd_row;

  rhd_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (pos.idx),
    .wdata (pair_now),
    .re    (line_re),
    .raddr (pos.idx),
    .rdata (line_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel <= '0;
    end else if (in_accept && pos.in_image && !pos.odd_col) begin
      left_pixel <= pix;
    end
  end

  // stage 1: holds the lower pair sum while the ram returns the upper one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= line_re;
    end
  end

  always_ff @(posedge clk) begin
    if (line_re) begin
      s1_sum       <= pair_now;
      s1_row_end   <= pos.row_end;
      s1_frame_end <= pos.frame_end;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_free) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_free) begin
      out_pixel     <= quad_avg(pair_t'(line_rdata), s1_sum);
      out_row_end   <= s1_row_end;
      out_frame_end <= s1_frame_end;
    end
  end

  assign pix_out.valid     = out_valid;
  assign pix_out.red_out   = out_pixel.red;
  assign pix_out.green_out = out_pixel.green;
  assign pix_out.blue_out  = out_pixel.blue;
  assign pix_out.alpha_out = out_pixel.alpha;
  assign pix_out.row_end   = out_row_end;
  assign pix_out.frame_end = out_frame_end;

  // frame end only ever closes a row
  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_frame_end || out_row_end))
    else $error("frame end without row end");

  // a blocked stage keeps its word
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_free) |=> (s1_valid && $stable(s1_sum)))
    else $error("stage 1 word lost while stalled");

  // a word that moves on from stage 1 lands in the result register
  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_free) |=> out_valid)
    else $error("stage 1 word dropped");

  // an even-row store never produces a result
  a_store_no_emit: assert property (@(posedge clk) disable iff (rst)
    line_we |=> !s1_valid)
    else $error("result from an even-row pixel");

endmodule
